[rtl/cpu8_register_flag_execute_macros.svh]
// Assertion macros for the file that checks the execute unit.
// Each one samples on the rising edge of clk and is held off while rst_n is low.
`ifndef CPU8_REGISTER_FLAG_EXECUTE_MACROS_SVH
`define CPU8_REGISTER_FLAG_EXECUTE_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define CPU8RFE_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The property must hold in the cycle after the condition.
`define CPU8RFE_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/cpu8rfe_pkg.sv]
package cpu8rfe_pkg;

    localparam logic [8:0] STACK_PAGE = 9'h100;
    localparam logic [7:0] SP_RESET   = 8'hFD;

    typedef enum logic [5:0] {
        OP_LDA = 6'd0,
        OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY, OP_TAX, OP_TAY,
        OP_TXA, OP_TYA, OP_TSX, OP_TXS, OP_AND, OP_ORA, OP_EOR, OP_BIT,
        OP_ADC, OP_SBC, OP_CMP, OP_CPX, OP_CPY, OP_INC, OP_DEC, OP_INX,
        OP_INY, OP_DEX, OP_DEY, OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_CLC,
        OP_SEC, OP_CLD, OP_SED, OP_CLI, OP_SEI, OP_CLV, OP_PHA, OP_PLA,
        OP_PHP, OP_PLP, OP_BCC, OP_BCS, OP_BNE, OP_BEQ, OP_BPL, OP_BMI,
        OP_BVC, OP_BVS, OP_NOP
    } op_t;

    typedef struct packed {
        logic n;
        logic v;
        logic b;
        logic d;
        logic i;
        logic z;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        flags_t     flags;
    } state_t;

    typedef struct packed {
        logic [5:0] mode;
        logic [7:0] operand;
        logic       on_accumulator;
    } in_item_t;

    typedef struct packed {
        logic [7:0] write_data;
        logic       write_memory;
        logic [8:0] stack_addr;
        logic       stack_access;
        logic       branch_taken;
        logic [7:0] acc_value;
        logic [7:0] x_value;
        logic [7:0] y_value;
        logic [7:0] sp_value;
        logic [7:0] status_byte;
        logic       illegal;
    } out_item_t;

endpackage

[rtl/cpu8rfe_in_if.sv]
interface cpu8rfe_in_if;
    logic                   valid;
    logic                   ready;
    cpu8rfe_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/cpu8rfe_out_if.sv]
interface cpu8rfe_out_if;
    logic                   valid;
    logic                   ready;
    cpu8rfe_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/cpu8rfe_state.sv]
module cpu8rfe_state (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  update,
    input  cpu8rfe_pkg::state_t   state_next,
    output cpu8rfe_pkg::state_t   state
);

    cpu8rfe_pkg::state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.acc   <= 8'd0;
            state_reg.x     <= 8'd0;
            state_reg.y     <= 8'd0;
            state_reg.sp    <= cpu8rfe_pkg::SP_RESET;
            state_reg.flags <= '0;
        end
        else if (update)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

[rtl/cpu8rfe_exec.sv]
module cpu8rfe_exec (
    input  cpu8rfe_pkg::in_item_t  item,
    input  cpu8rfe_pkg::state_t    cur,
    output cpu8rfe_pkg::state_t    nxt,
    output cpu8rfe_pkg::out_item_t res
);

    logic [7:0] src;
    logic [7:0] addend;
    logic [8:0] sum;
    logic [7:0] cmp_reg;
    logic [8:0] diff;
    logic [7:0] sh_r;
    logic       sh_c;
    logic [7:0] wdata;
    logic       wmem;
    logic       sacc;
    logic       taken;
    logic       push;
    logic [7:0] tmp;

    function automatic cpu8rfe_pkg::flags_t set_nz(input cpu8rfe_pkg::flags_t f,
                                                   input logic [7:0] v);
        cpu8rfe_pkg::flags_t g;
        g   = f;
        g.n = v[7];
        g.z = (v == 8'd0);
        return g;
    endfunction

    always_comb
    begin
        src    = item.on_accumulator ? cur.acc : item.operand;
        addend = (item.mode == cpu8rfe_pkg::OP_SBC) ? ~item.operand : item.operand;
        sum    = {1'b0, cur.acc} + {1'b0, addend} + {8'd0, cur.flags.c};

        if (item.mode == cpu8rfe_pkg::OP_CPX)
            cmp_reg = cur.x;
        else if (item.mode == cpu8rfe_pkg::OP_CPY)
            cmp_reg = cur.y;
        else
            cmp_reg = cur.acc;
        diff = {1'b0, cmp_reg} - {1'b0, item.operand};

        if (item.mode == cpu8rfe_pkg::OP_ASL)
        begin
            sh_r = {src[6:0], 1'b0};
            sh_c = src[7];
        end
        else if (item.mode == cpu8rfe_pkg::OP_ROL)
        begin
            sh_r = {src[6:0], cur.flags.c};
            sh_c = src[7];
        end
        else if (item.mode == cpu8rfe_pkg::OP_ROR)
        begin
            sh_r = {cur.flags.c, src[7:1]};
            sh_c = src[0];
        end
        else
        begin
            sh_r = {1'b0, src[7:1]};
            sh_c = src[0];
        end

        nxt   = cur;
        wdata = 8'd0;
        wmem  = 1'b0;
        sacc  = 1'b0;
        taken = 1'b0;
        push  = 1'b0;
        tmp   = 8'd0;

        case (cpu8rfe_pkg::op_t'(item.mode))
            cpu8rfe_pkg::OP_LDA:
            begin
                nxt.acc   = item.operand;
                nxt.flags = set_nz(cur.flags, item.operand);
            end
            cpu8rfe_pkg::OP_LDX:
            begin
                nxt.x     = item.operand;
                nxt.flags = set_nz(cur.flags, item.operand);
            end
            cpu8rfe_pkg::OP_LDY:
            begin
                nxt.y     = item.operand;
                nxt.flags = set_nz(cur.flags, item.operand);
            end
            cpu8rfe_pkg::OP_STA:
            begin
                wdata = cur.acc;
                wmem  = 1'b1;
            end
            cpu8rfe_pkg::OP_STX:
            begin
                wdata = cur.x;
                wmem  = 1'b1;
            end
            cpu8rfe_pkg::OP_STY:
            begin
                wdata = cur.y;
                wmem  = 1'b1;
            end
            cpu8rfe_pkg::OP_TAX:
            begin
                nxt.x     = cur.acc;
                nxt.flags = set_nz(cur.flags, cur.acc);
            end
            cpu8rfe_pkg::OP_TAY:
            begin
                nxt.y     = cur.acc;
                nxt.flags = set_nz(cur.flags, cur.acc);
            end
            cpu8rfe_pkg::OP_TXA:
            begin
                nxt.acc   = cur.x;
                nxt.flags = set_nz(cur.flags, cur.x);
            end
            cpu8rfe_pkg::OP_TYA:
            begin
                nxt.acc   = cur.y;
                nxt.flags = set_nz(cur.flags, cur.y);
            end
            cpu8rfe_pkg::OP_TSX:
            begin
                nxt.x     = cur.sp;
                nxt.flags = set_nz(cur.flags, cur.sp);
            end
            cpu8rfe_pkg::OP_TXS:
            begin
                nxt.sp = cur.x;
            end
            cpu8rfe_pkg::OP_AND:
            begin
                tmp       = cur.acc & item.operand;
                nxt.acc   = tmp;
                nxt.flags = set_nz(cur.flags, tmp);
            end
            cpu8rfe_pkg::OP_ORA:
            begin
                tmp       = cur.acc | item.operand;
                nxt.acc   = tmp;
                nxt.flags = set_nz(cur.flags, tmp);
            end
            cpu8rfe_pkg::OP_EOR:
            begin
                tmp       = cur.acc ^ item.operand;
                nxt.acc   = tmp;
                nxt.flags = set_nz(cur.flags, tmp);
            end
            cpu8rfe_pkg::OP_BIT:
            begin
                nxt.flags.z = ((cur.acc & item.operand) == 8'd0);
                nxt.flags.n = item.operand[7];
                nxt.flags.v = item.operand[6];
            end
            cpu8rfe_pkg::OP_ADC, cpu8rfe_pkg::OP_SBC:
            begin
                tmp         = sum[7:0];
                nxt.acc     = tmp;
                nxt.flags   = set_nz(cur.flags, tmp);
                nxt.flags.c = sum[8];
                nxt.flags.v = ~(cur.acc[7] ^ addend[7]) & (cur.acc[7] ^ tmp[7]);
            end
            cpu8rfe_pkg::OP_CMP, cpu8rfe_pkg::OP_CPX, cpu8rfe_pkg::OP_CPY:
            begin
                nxt.flags   = set_nz(cur.flags, diff[7:0]);
                nxt.flags.c = ~diff[8];
            end
            cpu8rfe_pkg::OP_INC:
            begin
                tmp       = item.operand + 8'd1;
                wdata     = tmp;
                wmem      = 1'b1;
                nxt.flags = set_nz(cur.flags, tmp);
            end
            cpu8rfe_pkg::OP_DEC:
            begin
                tmp       = item.operand - 8'd1;
                wdata     = tmp;
                wmem      = 1'b1;
                nxt.flags = set_nz(cur.flags, tmp);
            end
            cpu8rfe_pkg::OP_INX:
            begin
                tmp       = cur.x + 8'd1;
                nxt.x     = tmp;
                nxt.flags = set_nz(cur.flags, tmp);
            end
            cpu8rfe_pkg::OP_INY:
            begin
                tmp       = cur.y + 8'd1;
                nxt.y     = tmp;
                nxt.flags = set_nz(cur.flags, tmp);
            end
            cpu8rfe_pkg::OP_DEX:
            begin
                tmp       = cur.x - 8'd1;
                nxt.x     = tmp;
                nxt.flags = set_nz(cur.flags, tmp);
            end
            cpu8rfe_pkg::OP_DEY:
            begin
                tmp       = cur.y - 8'd1;
                nxt.y     = tmp;
                nxt.flags = set_nz(cur.flags, tmp);
            end
            cpu8rfe_pkg::OP_ASL, cpu8rfe_pkg::OP_LSR,
            cpu8rfe_pkg::OP_ROL, cpu8rfe_pkg::OP_ROR:
            begin
                nxt.flags   = set_nz(cur.flags, sh_r);
                nxt.flags.c = sh_c;
                if (item.on_accumulator)
                begin
                    nxt.acc = sh_r;
                end
                else
                begin
                    wdata = sh_r;
                    wmem  = 1'b1;
                end
            end
            cpu8rfe_pkg::OP_CLC: nxt.flags.c = 1'b0;
            cpu8rfe_pkg::OP_SEC: nxt.flags.c = 1'b1;
            cpu8rfe_pkg::OP_CLD: nxt.flags.d = 1'b0;
            cpu8rfe_pkg::OP_SED: nxt.flags.d = 1'b1;
            cpu8rfe_pkg::OP_CLI: nxt.flags.i = 1'b0;
            cpu8rfe_pkg::OP_SEI: nxt.flags.i = 1'b1;
            cpu8rfe_pkg::OP_CLV: nxt.flags.v = 1'b0;
            cpu8rfe_pkg::OP_PHA, cpu8rfe_pkg::OP_PHP:
            begin
                if (item.mode == cpu8rfe_pkg::OP_PHA)
                    wdata = cur.acc;
                else
                    wdata = {cur.flags.n, cur.flags.v, 1'b1, 1'b1,
                             cur.flags.d, cur.flags.i, cur.flags.z, cur.flags.c};
                wmem   = 1'b1;
                sacc   = 1'b1;
                push   = 1'b1;
                nxt.sp = cur.sp - 8'd1;
            end
            cpu8rfe_pkg::OP_PLA:
            begin
                sacc      = 1'b1;
                nxt.sp    = cur.sp + 8'd1;
                nxt.acc   = item.operand;
                nxt.flags = set_nz(cur.flags, item.operand);
            end
            cpu8rfe_pkg::OP_PLP:
            begin
                sacc        = 1'b1;
                nxt.sp      = cur.sp + 8'd1;
                nxt.flags.n = item.operand[7];
                nxt.flags.v = item.operand[6];
                nxt.flags.b = item.operand[4];
                nxt.flags.d = item.operand[3];
                nxt.flags.i = item.operand[2];
                nxt.flags.z = item.operand[1];
                nxt.flags.c = item.operand[0];
            end
            cpu8rfe_pkg::OP_BCC: taken = ~cur.flags.c;
            cpu8rfe_pkg::OP_BCS: taken = cur.flags.c;
            cpu8rfe_pkg::OP_BNE: taken = ~cur.flags.z;
            cpu8rfe_pkg::OP_BEQ: taken = cur.flags.z;
            cpu8rfe_pkg::OP_BPL: taken = ~cur.flags.n;
            cpu8rfe_pkg::OP_BMI: taken = cur.flags.n;
            cpu8rfe_pkg::OP_BVC: taken = ~cur.flags.v;
            cpu8rfe_pkg::OP_BVS: taken = cur.flags.v;
            default:
            begin
                nxt = cur;
            end
        endcase

        res.write_data    = wdata;
        res.write_memory  = wmem;
        res.stack_addr    = cpu8rfe_pkg::STACK_PAGE | {1'b0, (push ? cur.sp : nxt.sp)};
        res.stack_access  = sacc;
        res.branch_taken  = taken;
        res.acc_value     = nxt.acc;
        res.x_value       = nxt.x;
        res.y_value       = nxt.y;
        res.sp_value      = nxt.sp;
        res.status_byte   = {nxt.flags.n, nxt.flags.v, 1'b1, nxt.flags.b,
                             nxt.flags.d, nxt.flags.i, nxt.flags.z, nxt.flags.c};
        res.illegal       = (item.mode > 6'(cpu8rfe_pkg::OP_NOP));
    end

endmodule

[rtl/cpu8_register_flag_execute.sv]
// Execute unit of an 8-bit accumulator CPU in binary mode. It holds A, X, Y, the stack
// pointer and the flags, takes one operation item per cycle and returns one result item
// for each, in order. An accepted item is registered, executed combinationally against
// the register file, and its result (write byte and strobe, stack address and strobe,
// branch condition, registers and status afterward) is loaded into the output register.
// The sustained rate is one item per cycle; the input stalls only when both the input
// and the output register hold items and the result side holds ready low. Illegal codes
// return the current state with the illegal bit set and change nothing.
`include "cpu8_register_flag_execute_macros.svh"

module cpu8_register_flag_execute (
    input  logic               clk,
    input  logic               rst_n,
    cpu8rfe_in_if.sink         cmd,
    cpu8rfe_out_if.source      rsp
);

    logic                    in_valid_reg;
    logic                    in_valid_next;
    cpu8rfe_pkg::in_item_t   in_data_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    cpu8rfe_pkg::out_item_t  out_data_reg;
    logic                    advance;
    logic                    exec_fire;
    cpu8rfe_pkg::state_t     cur_state;
    cpu8rfe_pkg::state_t     nxt_state;
    cpu8rfe_pkg::out_item_t  exec_res;

    assign advance   = ~out_valid_reg | rsp.ready;
    assign exec_fire = in_valid_reg & advance;
    assign cmd.ready = ~in_valid_reg | advance;

    always_comb
    begin
        in_valid_next  = cmd.ready ? cmd.valid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_data_reg <= cmd.data;
        end
        if (exec_fire)
        begin
            out_data_reg <= exec_res;
        end
    end

    cpu8rfe_exec u_exec (
        .item (in_data_reg),
        .cur  (cur_state),
        .nxt  (nxt_state),
        .res  (exec_res)
    );

    cpu8rfe_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (exec_fire),
        .state_next (nxt_state),
        .state      (cur_state)
    );

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    `CPU8RFE_ASSERT_NEXT(a_illegal_keeps_state, exec_fire && exec_res.illegal, $stable(cur_state), "illegal item changed state")
    `CPU8RFE_ASSERT_NEXT(a_push_decrements_sp, exec_fire && (in_data_reg.mode == cpu8rfe_pkg::OP_PHA || in_data_reg.mode == cpu8rfe_pkg::OP_PHP), cur_state.sp == $past(cur_state.sp) - 8'd1, "push did not decrement sp")
    `CPU8RFE_ASSERT_NOW(a_no_write_zero_data, out_valid_reg && !out_data_reg.write_memory, out_data_reg.write_data == 8'd0, "write data nonzero without write")
    `CPU8RFE_ASSERT_NOW(a_branch_no_side_effect, out_valid_reg && out_data_reg.branch_taken, !out_data_reg.write_memory && !out_data_reg.stack_access, "taken branch with memory access")

endmodule

[tb/tb_cpu8_register_flag_execute.sv]
`timescale 1ns / 100ps

module tb_cpu8_register_flag_execute;

    localparam logic [5:0] FIRST_ILLEGAL = 6'd51;
    localparam logic [5:0] LAST_ILLEGAL  = 6'd63;
    localparam logic [7:0] PUSHED_BREAK  = 8'h10;
    localparam int RANDOM_PER_PHASE = 115;
    localparam int HOLD_CYCLES      = 60;
    localparam int MAX_REPORTS      = 10;
    localparam int SETTLE_CYCLES    = 10;

    logic clk;
    logic rst_n;

    cpu8rfe_in_if  cmd_if ();
    cpu8rfe_out_if rsp_if ();

    cpu8_register_flag_execute i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    cpu8rfe_pkg::in_item_t  pending_ops[$];
    cpu8rfe_pkg::out_item_t expected_results[$];

    logic [7:0]          model_acc;
    logic [7:0]          model_x;
    logic [7:0]          model_y;
    logic [7:0]          model_sp;
    cpu8rfe_pkg::flags_t model_flags;

    logic [7:0] corner_bytes[5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};

    int        send_idle_pct;
    int        recv_stall_pct;
    logic      recv_hold;
    logic      hold_request;
    logic      cmd_taken;
    int        items_accepted;
    int        results_checked;
    int        error_count;
    int        branches_taken;
    bit [63:0] modes_seen;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [7:0] status_byte_of(cpu8rfe_pkg::flags_t f);
        return {f.n, f.v, 1'b1, f.b, f.d, f.i, f.z, f.c};
    endfunction

    task automatic set_nz(input logic [7:0] v);
        model_flags.n = v[7];
        model_flags.z = (v == 8'h00);
    endtask

    task automatic add_to_acc(input logic [7:0] m);
        logic [8:0] sum;
        logic [7:0] r;
        sum = {1'b0, model_acc} + {1'b0, m} + {8'h00, model_flags.c};
        r = sum[7:0];
        model_flags.c = sum[8];
        model_flags.v = ~(model_acc[7] ^ m[7]) & (model_acc[7] ^ r[7]);
        set_nz(r);
        model_acc = r;
    endtask

    task automatic compare_with(input logic [7:0] register_value, input logic [7:0] m);
        model_flags.c = (register_value >= m);
        set_nz(register_value - m);
    endtask

    task automatic execute_op(input cpu8rfe_pkg::in_item_t op,
                              output cpu8rfe_pkg::out_item_t res);
        logic [7:0] m;
        logic [7:0] src;
        logic [7:0] r;
        logic       old_c;
        m = op.operand;
        src = op.on_accumulator ? model_acc : m;
        old_c = model_flags.c;
        res = '0;
        res.illegal = (op.mode >= FIRST_ILLEGAL);
        case (cpu8rfe_pkg::op_t'(op.mode))
            cpu8rfe_pkg::OP_LDA:
            begin
                model_acc = m;
                set_nz(m);
            end
            cpu8rfe_pkg::OP_LDX:
            begin
                model_x = m;
                set_nz(m);
            end
            cpu8rfe_pkg::OP_LDY:
            begin
                model_y = m;
                set_nz(m);
            end
            cpu8rfe_pkg::OP_STA:
            begin
                res.write_data = model_acc;
                res.write_memory = 1'b1;
            end
            cpu8rfe_pkg::OP_STX:
            begin
                res.write_data = model_x;
                res.write_memory = 1'b1;
            end
            cpu8rfe_pkg::OP_STY:
            begin
                res.write_data = model_y;
                res.write_memory = 1'b1;
            end
            cpu8rfe_pkg::OP_TAX:
            begin
                model_x = model_acc;
                set_nz(model_x);
            end
            cpu8rfe_pkg::OP_TAY:
            begin
                model_y = model_acc;
                set_nz(model_y);
            end
            cpu8rfe_pkg::OP_TXA:
            begin
                model_acc = model_x;
                set_nz(model_acc);
            end
            cpu8rfe_pkg::OP_TYA:
            begin
                model_acc = model_y;
                set_nz(model_acc);
            end
            cpu8rfe_pkg::OP_TSX:
            begin
                model_x = model_sp;
                set_nz(model_x);
            end
            cpu8rfe_pkg::OP_TXS: model_sp = model_x;
            cpu8rfe_pkg::OP_AND:
            begin
                model_acc = model_acc & m;
                set_nz(model_acc);
            end
            cpu8rfe_pkg::OP_ORA:
            begin
                model_acc = model_acc | m;
                set_nz(model_acc);
            end
            cpu8rfe_pkg::OP_EOR:
            begin
                model_acc = model_acc ^ m;
                set_nz(model_acc);
            end
            cpu8rfe_pkg::OP_BIT:
            begin
                model_flags.z = ((model_acc & m) == 8'h00);
                model_flags.n = m[7];
                model_flags.v = m[6];
            end
            cpu8rfe_pkg::OP_ADC: add_to_acc(m);
            cpu8rfe_pkg::OP_SBC: add_to_acc(~m);
            cpu8rfe_pkg::OP_CMP: compare_with(model_acc, m);
            cpu8rfe_pkg::OP_CPX: compare_with(model_x, m);
            cpu8rfe_pkg::OP_CPY: compare_with(model_y, m);
            cpu8rfe_pkg::OP_INC, cpu8rfe_pkg::OP_DEC:
            begin
                res.write_data = (op.mode == cpu8rfe_pkg::OP_INC) ? m + 8'd1 : m - 8'd1;
                res.write_memory = 1'b1;
                set_nz(res.write_data);
            end
            cpu8rfe_pkg::OP_INX:
            begin
                model_x = model_x + 8'd1;
                set_nz(model_x);
            end
            cpu8rfe_pkg::OP_INY:
            begin
                model_y = model_y + 8'd1;
                set_nz(model_y);
            end
            cpu8rfe_pkg::OP_DEX:
            begin
                model_x = model_x - 8'd1;
                set_nz(model_x);
            end
            cpu8rfe_pkg::OP_DEY:
            begin
                model_y = model_y - 8'd1;
                set_nz(model_y);
            end
            cpu8rfe_pkg::OP_ASL, cpu8rfe_pkg::OP_LSR,
            cpu8rfe_pkg::OP_ROL, cpu8rfe_pkg::OP_ROR:
            begin
                case (cpu8rfe_pkg::op_t'(op.mode))
                    cpu8rfe_pkg::OP_ASL: r = {src[6:0], 1'b0};
                    cpu8rfe_pkg::OP_LSR: r = {1'b0, src[7:1]};
                    cpu8rfe_pkg::OP_ROL: r = {src[6:0], old_c};
                    default: r = {old_c, src[7:1]};
                endcase
                model_flags.c = (op.mode == cpu8rfe_pkg::OP_ASL ||
                                 op.mode == cpu8rfe_pkg::OP_ROL) ? src[7] : src[0];
                set_nz(r);
                if (op.on_accumulator)
                    model_acc = r;
                else
                begin
                    res.write_data = r;
                    res.write_memory = 1'b1;
                end
            end
            cpu8rfe_pkg::OP_CLC: model_flags.c = 1'b0;
            cpu8rfe_pkg::OP_SEC: model_flags.c = 1'b1;
            cpu8rfe_pkg::OP_CLD: model_flags.d = 1'b0;
            cpu8rfe_pkg::OP_SED: model_flags.d = 1'b1;
            cpu8rfe_pkg::OP_CLI: model_flags.i = 1'b0;
            cpu8rfe_pkg::OP_SEI: model_flags.i = 1'b1;
            cpu8rfe_pkg::OP_CLV: model_flags.v = 1'b0;
            cpu8rfe_pkg::OP_PHA, cpu8rfe_pkg::OP_PHP:
            begin
                res.write_data = (op.mode == cpu8rfe_pkg::OP_PHA)
                                 ? model_acc
                                 : status_byte_of(model_flags) | PUSHED_BREAK;
                res.write_memory = 1'b1;
                res.stack_access = 1'b1;
                res.stack_addr = cpu8rfe_pkg::STACK_PAGE | {1'b0, model_sp};
                model_sp = model_sp - 8'd1;
            end
            cpu8rfe_pkg::OP_PLA, cpu8rfe_pkg::OP_PLP:
            begin
                model_sp = model_sp + 8'd1;
                res.stack_access = 1'b1;
                if (op.mode == cpu8rfe_pkg::OP_PLA)
                begin
                    model_acc = m;
                    set_nz(m);
                end
                else
                    model_flags = {m[7], m[6], m[4], m[3], m[2], m[1], m[0]};
            end
            cpu8rfe_pkg::OP_BCC: res.branch_taken = !model_flags.c;
            cpu8rfe_pkg::OP_BCS: res.branch_taken = model_flags.c;
            cpu8rfe_pkg::OP_BNE: res.branch_taken = !model_flags.z;
            cpu8rfe_pkg::OP_BEQ: res.branch_taken = model_flags.z;
            cpu8rfe_pkg::OP_BPL: res.branch_taken = !model_flags.n;
            cpu8rfe_pkg::OP_BMI: res.branch_taken = model_flags.n;
            cpu8rfe_pkg::OP_BVC: res.branch_taken = !model_flags.v;
            cpu8rfe_pkg::OP_BVS: res.branch_taken = model_flags.v;
            default: ;
        endcase
        if (!(res.stack_access && res.write_memory))
            res.stack_addr = cpu8rfe_pkg::STACK_PAGE | {1'b0, model_sp};
        res.acc_value = model_acc;
        res.x_value = model_x;
        res.y_value = model_y;
        res.sp_value = model_sp;
        res.status_byte = status_byte_of(model_flags);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("Mismatch in result %0d, %s: expected %0h, got %0h",
                         results_checked, name, want, got);
        end
    endtask

    task automatic compare_result(input cpu8rfe_pkg::out_item_t want,
                                  input cpu8rfe_pkg::out_item_t got);
        check_field("write_data", want.write_data, got.write_data);
        check_field("write_memory", want.write_memory, got.write_memory);
        check_field("stack_addr", want.stack_addr, got.stack_addr);
        check_field("stack_access", want.stack_access, got.stack_access);
        check_field("branch_taken", want.branch_taken, got.branch_taken);
        check_field("acc_value", want.acc_value, got.acc_value);
        check_field("x_value", want.x_value, got.x_value);
        check_field("y_value", want.y_value, got.y_value);
        check_field("sp_value", want.sp_value, got.sp_value);
        check_field("status_byte", want.status_byte, got.status_byte);
        check_field("illegal", want.illegal, got.illegal);
    endtask

    always @(posedge clk)
    begin : monitor
        cpu8rfe_pkg::out_item_t predicted;
        cpu8rfe_pkg::out_item_t oldest;
        if (!rst_n)
            cmd_taken <= 1'b0;
        else
        begin
            cmd_taken <= cmd_if.valid && cmd_if.ready;
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("Result item arrived with nothing outstanding: %h",
                                 rsp_if.data);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    compare_result(oldest, rsp_if.data);
                    if (oldest.branch_taken)
                        branches_taken++;
                    results_checked++;
                end
            end
            if (cmd_if.valid && cmd_if.ready)
            begin
                execute_op(cmd_if.data, predicted);
                expected_results.push_back(predicted);
                modes_seen[cmd_if.data.mode] = 1'b1;
                items_accepted++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_if.valid <= 1'b0;
        else if (!cmd_if.valid || cmd_taken)
        begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd_if.valid <= 1'b1;
                cmd_if.data <= pending_ops.pop_front();
            end
            else
                cmd_if.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || recv_hold)
            rsp_if.ready <= 1'b0;
        else
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The output side holds off for a fixed stretch so the block fills and stalls its input.
    initial
    begin
        recv_hold = 1'b0;
        wait (hold_request);
        @(posedge clk);
        recv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold = 1'b0;
    end

    task automatic add_op(input logic [5:0] mode, input logic [7:0] operand, input logic on_acc);
        cpu8rfe_pkg::in_item_t op;
        op.mode = mode;
        op.operand = operand;
        op.on_accumulator = on_acc;
        pending_ops.push_back(op);
    endtask

    task automatic queue_directed_ops();
        int code;
        add_op(cpu8rfe_pkg::OP_LDA, 8'h00, 1'b1);
        add_op(cpu8rfe_pkg::OP_LDA, 8'h7F, 1'b0);
        add_op(cpu8rfe_pkg::OP_ADC, 8'h01, 1'b0);
        add_op(cpu8rfe_pkg::OP_BVS, 8'h00, 1'b0);
        add_op(cpu8rfe_pkg::OP_SBC, 8'h00, 1'b1);
        add_op(cpu8rfe_pkg::OP_SEC, 8'hFF, 1'b0);
        add_op(cpu8rfe_pkg::OP_ROR, 8'h00, 1'b1);
        add_op(cpu8rfe_pkg::OP_ROL, 8'hFF, 1'b0);
        add_op(cpu8rfe_pkg::OP_ASL, 8'h80, 1'b0);
        add_op(cpu8rfe_pkg::OP_LSR, 8'h01, 1'b1);
        add_op(cpu8rfe_pkg::OP_LDX, 8'h00, 1'b0);
        add_op(cpu8rfe_pkg::OP_TXS, 8'hFF, 1'b1);
        add_op(cpu8rfe_pkg::OP_PHA, 8'h00, 1'b0);
        add_op(cpu8rfe_pkg::OP_PLA, 8'h55, 1'b0);
        add_op(cpu8rfe_pkg::OP_PHP, 8'h00, 1'b0);
        add_op(cpu8rfe_pkg::OP_PLP, 8'hFF, 1'b0);
        add_op(cpu8rfe_pkg::OP_BIT, 8'hC0, 1'b0);
        add_op(cpu8rfe_pkg::OP_CMP, 8'hFF, 1'b0);
        add_op(cpu8rfe_pkg::OP_CPX, 8'h00, 1'b0);
        add_op(cpu8rfe_pkg::OP_INC, 8'hFF, 1'b0);
        add_op(cpu8rfe_pkg::OP_DEC, 8'h00, 1'b0);
        add_op(cpu8rfe_pkg::OP_DEX, 8'h00, 1'b0);
        add_op(FIRST_ILLEGAL, 8'hAA, 1'b1);
        add_op(LAST_ILLEGAL, 8'hFF, 1'b1);
        add_op(cpu8rfe_pkg::OP_NOP, 8'h00, 1'b0);
        for (code = 0; code <= LAST_ILLEGAL; code++)
            add_op(6'(code), 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic queue_random_ops(input int count);
        int k;
        logic [5:0] mode;
        logic [7:0] operand;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(99) < 5)
                mode = 6'($urandom_range(LAST_ILLEGAL, FIRST_ILLEGAL));
            else
                mode = 6'($urandom_range(cpu8rfe_pkg::OP_NOP, cpu8rfe_pkg::OP_LDA));
            if ($urandom_range(4) == 0)
                operand = corner_bytes[$urandom_range(4)];
            else
                operand = 8'($urandom_range(255));
            add_op(mode, operand, 1'($urandom_range(1)));
        end
    endtask

    task automatic wait_for_drain();
        while (pending_ops.size() != 0 || cmd_if.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int phase;
        rst_n = 1'b0;
        hold_request = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        items_accepted = 0;
        results_checked = 0;
        error_count = 0;
        branches_taken = 0;
        modes_seen = '0;
        model_acc = 8'h00;
        model_x = 8'h00;
        model_y = 8'h00;
        model_sp = cpu8rfe_pkg::SP_RESET;
        model_flags = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        queue_directed_ops();
        wait_for_drain();
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_request = 1'b1;
                end
                1:
                begin
                    send_idle_pct = 75;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 75;
                end
                default:
                begin
                    send_idle_pct = 38;
                    recv_stall_pct = 38;
                end
            endcase
            queue_random_ops(RANDOM_PER_PHASE);
            wait_for_drain();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Executed %0d items and checked %0d results; %0d of 64 mode codes seen,",
                 items_accepted, results_checked, $countones(modes_seen));
        $display("%0d taken branches; traffic ran back to back with a long output stall,",
                 branches_taken);
        $display("then with sparse input, a slow receiver and mixed gaps.");
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/cpu8rfe_pkg.sv
rtl/cpu8rfe_in_if.sv
rtl/cpu8rfe_out_if.sv
rtl/cpu8rfe_state.sv
rtl/cpu8rfe_exec.sv
rtl/cpu8_register_flag_execute.sv
tb/tb_cpu8_register_flag_execute.sv
